// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the stack controller and datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BSR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bsr_pkg.sv =====
// Shared constants, codes and command/status types of the stack with rotate.
package bsr_pkg;

	localparam int DEFAULT_STACK_DEPTH = 32;

	localparam logic [5:0] CAP_RESET = 6'd32;

	// operation codes of an input item
	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_POP   = 3'd1;
	localparam logic [2:0] OP_PEEK  = 3'd2;
	localparam logic [2:0] OP_DUP   = 3'd3;
	localparam logic [2:0] OP_ROTU  = 3'd4;
	localparam logic [2:0] OP_ROTD  = 3'd5;
	localparam logic [2:0] OP_PRINT = 3'd6;

	// status codes of a result item
	localparam logic [2:0] ST_FULL  = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_PEEK  = 3'd2;
	localparam logic [2:0] ST_ENTRY = 3'd3;
	localparam logic [2:0] ST_BLANK = 3'd4;

	typedef enum logic [2:0] {
		SOP_NONE,
		SOP_PUSH,
		SOP_POP,
		SOP_DUP,
		SOP_ROTU,
		SOP_ROTD
	} sop_t;

	typedef struct packed {
		sop_t       sop;
		logic       out_load;
		logic [2:0] out_status;
		logic       out_data;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic rot_ok;
		logic one_entry;
		logic rd_last;
	} stat_t;

endpackage

// ===== rtl/core/bounded_stack_with_rotate.sv =====
// Top level of the bounded byte stack with rotate operations.
//
// Input channel (in_valid/in_ready) carries one operation item: operation,
// push_value and rotate_depth. Output channel (out_valid/out_ready) carries
// result items: status, data_byte and last. cfg_we/cfg_wdata write the
// capacity limit; write it only while the block is idle.
// Push, pop, duplicate and rotations finish in the accept cycle and give no
// result unless they report full or empty. Peek and error reports show up
// at the output register in the cycle after the item is accepted.
// Print streams the entries top first, one per cycle while out_ready stays
// high, and the block takes no new item until the last entry is loaded; the
// print cursor reads the entry row through one read port.
// An item is taken only while the output register is empty or being
// drained; a stalled receiver holds the result and blocks new items.
// Reset empties the stack, sets the limit to 32 and drops any pending
// result; entry contents are not cleared and need no clearing pass.
module bounded_stack_with_rotate
	import bsr_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [7:0] push_value,
	input  logic [5:0] rotate_depth,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [7:0] data_byte,
	output logic       last,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	cmd_t          cmd;
	stat_t         st;
	logic [AW-1:0] print_idx;

	// decode items and sequence the print stream
	bsr_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd),
		.print_idx (print_idx)
	);

	// hold the entries, the count, the limit and the result register
	bsr_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.print_idx    (print_idx),
		.push_value   (push_value),
		.rotate_depth (rotate_depth),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.st           (st),
		.status_q     (status),
		.data_q       (data_byte),
		.last_q       (last)
	);

endmodule

// ===== rtl/core/bsr_dp.sv =====
// Datapath of the stack: entry cells, count, limit register and result register.
module bsr_dp
	import bsr_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic [AW-1:0] print_idx,
	input  logic [7:0]    push_value,
	input  logic [5:0]    rotate_depth,
	input  logic          cfg_we,
	input  logic [5:0]    cfg_wdata,
	output stat_t         st,
	output logic [2:0]    status_q,
	output logic [7:0]    data_q,
	output logic          last_q
);

	localparam int CMPW = (CW > 6) ? CW : 6;

	logic [7:0]    cells_q [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [5:0]    cap_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [6:0]    n_ext;

	assign n_ext = {1'b0, rotate_depth};

	// one read port: the cell that rotate-down lifts, or the print cursor
	assign rd_addr = (cmd.sop == SOP_ROTD) ? AW'(rotate_depth - 6'd1) : print_idx;
	assign rd_data = cells_q[rd_addr];

	assign st.empty     = (count_q == '0);
	assign st.full      = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(STACK_DEPTH));
	assign st.rot_ok    = (rotate_depth >= 6'd2) && (CMPW'(rotate_depth) <= CMPW'(count_q));
	assign st.one_entry = (count_q == CW'(1));
	assign st.rd_last   = ((CW'(print_idx) + CW'(1)) == count_q);

	// cell 0 is the top; each cell picks from itself, a neighbor, the top cell, the read port or push_value
	for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
		logic [7:0] above;
		logic [7:0] below;
		if (j == 0) begin : g_top
			assign above = cells_q[0];
		end else begin : g_mid
			assign above = cells_q[j-1];
		end
		if (j == STACK_DEPTH - 1) begin : g_bot
			assign below = cells_q[j];
		end else begin : g_up
			assign below = cells_q[j+1];
		end

		always_ff @(posedge clk) begin
			unique case (cmd.sop)
				SOP_PUSH: cells_q[j] <= (j == 0) ? push_value : above;
				SOP_DUP:  cells_q[j] <= above;
				SOP_POP:  cells_q[j] <= below;
				SOP_ROTU: begin
					if (7'(j + 1) < n_ext) begin
						cells_q[j] <= below;
					end else if (7'(j + 1) == n_ext) begin
						cells_q[j] <= cells_q[0];
					end
				end
				SOP_ROTD: begin
					if (j == 0) begin
						cells_q[j] <= rd_data;
					end else if (7'(j + 1) <= n_ext) begin
						cells_q[j] <= above;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.sop == SOP_PUSH || cmd.sop == SOP_DUP) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.sop == SOP_POP) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			data_q   <= cmd.out_data ? rd_data : 8'd0;
			last_q   <= cmd.out_last;
		end
	end

`include "assert_macros.svh"

	`BSR_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(STACK_DEPTH), "count above depth")
	`BSR_ASSERT_NEXT(a_rot_keeps_count, cmd.sop == SOP_ROTU || cmd.sop == SOP_ROTD,
		$stable(count_q), "rotation changed count")

endmodule

// ===== rtl/core/bsr_ctrl.sv =====
// Controller of the stack: operation decode, print sequencer and result handshake.
module bsr_ctrl
	import bsr_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    operation,
	output logic          out_valid,
	input  logic          out_ready,
	input  stat_t         st,
	output cmd_t          cmd,
	output logic [AW-1:0] print_idx
);

	typedef enum logic {S_IDLE, S_PRINT} state_t;

	state_t        state_q, state_d;
	logic          out_valid_q;
	logic [AW-1:0] idx_q, idx_d;
	logic          can_load;
	logic          accept;

	assign can_load  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && can_load;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign print_idx = idx_q;

	always_comb begin
		cmd     = '0;
		cmd.sop = SOP_NONE;
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_PUSH: begin
							if (st.full) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = ST_FULL;
								cmd.out_last   = 1'b1;
							end else begin
								cmd.sop = SOP_PUSH;
							end
						end
						OP_POP: begin
							if (st.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = ST_EMPTY;
								cmd.out_last   = 1'b1;
							end else begin
								cmd.sop = SOP_POP;
							end
						end
						OP_PEEK: begin
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = st.empty ? ST_EMPTY : ST_PEEK;
							cmd.out_data   = !st.empty;
						end
						OP_DUP: begin
							if (st.empty || st.full) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = st.empty ? ST_EMPTY : ST_FULL;
								cmd.out_last   = 1'b1;
							end else begin
								cmd.sop = SOP_DUP;
							end
						end
						OP_ROTU: begin
							if (st.rot_ok) begin
								cmd.sop = SOP_ROTU;
							end
						end
						OP_ROTD: begin
							if (st.rot_ok) begin
								cmd.sop = SOP_ROTD;
							end
						end
						OP_PRINT: begin
							cmd.out_load = 1'b1;
							if (st.empty) begin
								cmd.out_status = ST_BLANK;
								cmd.out_last   = 1'b1;
							end else begin
								cmd.out_status = ST_ENTRY;
								cmd.out_data   = 1'b1;
								cmd.out_last   = st.one_entry;
								if (!st.one_entry) begin
									state_d = S_PRINT;
									idx_d   = AW'(1);
								end
							end
						end
						default: ;
					endcase
				end
			end
			S_PRINT: begin
				if (can_load) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = ST_ENTRY;
					cmd.out_data   = 1'b1;
					cmd.out_last   = st.rd_last;
					if (st.rd_last) begin
						state_d = S_IDLE;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + AW'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`include "assert_macros.svh"

	`BSR_ASSERT_ALWAYS(a_print_has_result, state_q != S_PRINT || out_valid_q,
		"print sequence without a pending result")
	`BSR_ASSERT_ALWAYS(a_idx_home, state_q == S_PRINT || idx_q == '0,
		"print cursor not parked at top while idle")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the bounded byte stack with rotate operations.
`timescale 1ns / 1ps

module testbench;
	import bsr_pkg::*;

	localparam int DEPTH = DEFAULT_STACK_DEPTH;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int ITEMS_PER_PHASE = 13;
	localparam int MAX_ERROR_LINES = 40;
	// the one operation code the block has no use for
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct {
		logic [2:0] op;
		logic [7:0] val;
		logic [5:0] depth;
	} item_t;

	typedef struct {
		logic [2:0] status;
		logic [7:0] data;
		logic       last;
	} result_t;

	// receiver stall patterns
	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] operation = '0;
	logic [7:0] push_value = '0;
	logic [5:0] rotate_depth = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] status;
	logic [7:0] data_byte;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;

	// items waiting for the driver, and results the stack model still owes
	item_t   pending_items[$];
	result_t expected_results[$];

	// stack model: entries, count and capacity limit
	logic [7:0] stack_mem [DEPTH];
	int         stack_cnt = 0;
	logic [5:0] cap_limit = CAP_RESET;

	// generator-side view of the count, used to aim rotation depths and to size the fill pushes
	int         gen_count = 0;
	logic [5:0] gen_limit = CAP_RESET;

	int error_count = 0;
	int results_seen = 0;

	bounded_stack_with_rotate #(.STACK_DEPTH(DEPTH)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.push_value  (push_value),
		.rotate_depth(rotate_depth),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.data_byte   (data_byte),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		if (error_count < MAX_ERROR_LINES) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	function automatic void expect_result(input logic [2:0] st, input logic [7:0] data,
			input logic lst);
		result_t r;
		r.status = st;
		r.data = data;
		r.last = lst;
		expected_results.push_back(r);
	endfunction

	// Apply one accepted item to the stack model and queue what it must produce.
	function automatic void apply_stack_op(input item_t it);
		int lim;
		int n;
		int i;
		logic [7:0] moved;
		// a limit above the depth is clamped to the depth
		lim = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
		n = int'(it.depth);
		case (it.op)
			OP_PUSH: begin
				// count at or above the limit, including a lowered limit: report full
				if (stack_cnt >= lim) begin
					expect_result(ST_FULL, 8'h00, 1'b1);
				end else begin
					stack_mem[stack_cnt] = it.val;
					stack_cnt++;
				end
			end
			OP_POP: begin
				if (stack_cnt == 0) begin
					expect_result(ST_EMPTY, 8'h00, 1'b1);
				end else begin
					stack_cnt--;
				end
			end
			OP_PEEK: begin
				if (stack_cnt == 0) begin
					expect_result(ST_EMPTY, 8'h00, 1'b1);
				end else begin
					expect_result(ST_PEEK, stack_mem[stack_cnt - 1], 1'b1);
				end
			end
			OP_DUP: begin
				// emptiness wins over fullness
				if (stack_cnt == 0) begin
					expect_result(ST_EMPTY, 8'h00, 1'b1);
				end else if (stack_cnt >= lim) begin
					expect_result(ST_FULL, 8'h00, 1'b1);
				end else begin
					stack_mem[stack_cnt] = stack_mem[stack_cnt - 1];
					stack_cnt++;
				end
			end
			OP_ROTU: begin
				// depth 0 or 1, or deeper than the count: leave the stack alone
				if (n >= 2 && n <= stack_cnt) begin
					moved = stack_mem[stack_cnt - 1];
					for (i = 1; i < n; i++) begin
						stack_mem[stack_cnt - i] = stack_mem[stack_cnt - i - 1];
					end
					stack_mem[stack_cnt - n] = moved;
				end
			end
			OP_ROTD: begin
				if (n >= 2 && n <= stack_cnt) begin
					moved = stack_mem[stack_cnt - n];
					for (i = n; i > 1; i--) begin
						stack_mem[stack_cnt - i] = stack_mem[stack_cnt - i + 1];
					end
					stack_mem[stack_cnt - 1] = moved;
				end
			end
			OP_PRINT: begin
				if (stack_cnt == 0) begin
					expect_result(ST_BLANK, 8'h00, 1'b1);
				end else begin
					for (i = 1; i <= stack_cnt; i++) begin
						expect_result(ST_ENTRY, stack_mem[stack_cnt - i], i == stack_cnt);
					end
				end
			end
			default: begin
				// unused code: no effect, no result
			end
		endcase
	endfunction

	// Queue one item for the driver and track the count the generator expects.
	task automatic queue_op(input logic [2:0] op, input logic [7:0] val,
			input logic [5:0] depth);
		item_t it;
		int lim;
		lim = (int'(gen_limit) < DEPTH) ? int'(gen_limit) : DEPTH;
		it.op = op;
		it.val = val;
		it.depth = depth;
		pending_items.push_back(it);
		case (op)
			OP_PUSH: begin
				if (gen_count < lim) gen_count++;
			end
			OP_POP: begin
				if (gen_count > 0) gen_count--;
			end
			OP_DUP: begin
				if (gen_count > 0 && gen_count < lim) gen_count++;
			end
			default: begin
			end
		endcase
	endtask

	// Hold until every queued item is taken and every owed result has come back.
	task automatic wait_for_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Write the capacity limit once the block has gone quiet.
	task automatic set_capacity(input logic [5:0] value);
		wait_for_idle();
		// a push or rotate may still be settling with no result to show for it
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_limit = value;
		gen_limit = value;
		@(negedge clk);
	endtask

	// Driver: offer items in bursts of random length, with random gaps between.
	int    burst_left = 0;
	int    gap_left = 0;
	item_t drive_item;
	logic  next_valid;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			next_valid = in_valid;
			// drop the item once it is taken
			if (in_valid && in_ready) begin
				pending_items.delete(0);
				next_valid = 1'b0;
			end
			if (!next_valid && pending_items.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					drive_item = pending_items[0];
					operation <= drive_item.op;
					push_value <= drive_item.val;
					rotate_depth <= drive_item.depth;
					next_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// start a new burst; a quarter of them follow with no gap at all
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			// one assignment per edge, so a valid held for the next item never dips
			in_valid <= next_valid;
		end
	end

	// Receiver: stall on a changing pattern, plus one long hold-off that backs the
	// block up until it refuses new items.
	rx_mode_t rx_mode = RX_ALWAYS;
	int       mode_left = 0;
	int       hold_left = 0;
	int       rx_tick = 0;
	logic     hold_done = 1'b0;
	logic     next_ready;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode = RX_ALWAYS;
			mode_left = 0;
			hold_left = 0;
			rx_tick = 0;
			hold_done = 1'b0;
		end else begin
			rx_tick++;
			if (!hold_done && results_seen >= 60) begin
				hold_left = LONG_HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:   next_ready = 1'b1;
					RX_COIN:     next_ready = 1'($urandom_range(0, 1));
					RX_SPARSE:   next_ready = ($urandom_range(0, 3) == 0);
					default:     next_ready = (rx_tick % 5) != 0;
				endcase
			end
			out_ready <= next_ready;
		end
	end

	// Monitor: check each result against the oldest expectation, then advance
	// the stack model with any item taken at this edge.
	result_t want;
	item_t   taken;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					report_error($sformatf("unexpected result status=%0d data=%02h last=%0b",
						status, data_byte, last));
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_error($sformatf("status %0d, expected %0d", status, want.status));
					if (data_byte !== want.data)
						report_error($sformatf("data_byte %02h, expected %02h", data_byte,
							want.data));
					if (last !== want.last)
						report_error($sformatf("last %0b, expected %0b", last, want.last));
				end
			end
			if (in_valid && in_ready) begin
				taken.op = operation;
				taken.val = push_value;
				taken.depth = rotate_depth;
				apply_stack_op(taken);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TIMEOUT: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int p;
		int r;
		int lim;
		logic [5:0] cap;
		logic [5:0] depth;
		logic [2:0] op;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty stack: every reporting operation, an unused code and an up-rotation
		queue_op(OP_PEEK, 8'h00, 6'd0);
		queue_op(OP_POP, 8'hFF, 6'd63);
		queue_op(OP_DUP, 8'h00, 6'd0);
		queue_op(OP_PRINT, 8'h00, 6'd0);
		queue_op(OP_UNUSED, 8'hFF, 6'd63);
		queue_op(OP_ROTU, 8'h00, 6'd3);
		// byte extremes, duplicate, peek
		queue_op(OP_PUSH, 8'h00, 6'd0);
		queue_op(OP_PUSH, 8'hFF, 6'd0);
		queue_op(OP_PUSH, 8'hA5, 6'd0);
		queue_op(OP_PUSH, 8'h5A, 6'd0);
		queue_op(OP_DUP, 8'h00, 6'd0);
		queue_op(OP_PEEK, 8'h00, 6'd0);
		// rotations of depth zero and one do nothing
		queue_op(OP_ROTU, 8'h00, 6'd0);
		queue_op(OP_ROTD, 8'h00, 6'd1);
		queue_op(OP_PUSH, 8'h3C, 6'd0);
		queue_op(OP_ROTU, 8'h00, 6'd4);
		queue_op(OP_ROTD, 8'h00, 6'd6);
		// deeper than the count: ignored
		queue_op(OP_ROTU, 8'h00, 6'd7);
		queue_op(OP_ROTD, 8'h00, 6'd32);
		queue_op(OP_PRINT, 8'h00, 6'd0);
		queue_op(OP_POP, 8'h00, 6'd0);

		// lower the limit below the count: entries stay, push and duplicate report full
		set_capacity(6'd3);
		queue_op(OP_PUSH, 8'h77, 6'd0);
		queue_op(OP_DUP, 8'h00, 6'd0);
		queue_op(OP_POP, 8'h00, 6'd0);
		queue_op(OP_PUSH, 8'h88, 6'd0);
		queue_op(OP_PRINT, 8'h00, 6'd0);

		// random phases over a range of limits, the extremes first
		for (p = 0; p < 10; p++) begin
			case (p)
				0: cap = 6'd0;
				1: cap = 6'd1;
				2: cap = 6'd63;
				3: cap = 6'd2;
				4: cap = 6'd32;
				5: cap = 6'd33;
				default: cap = 6'($urandom_range(1, 32));
			endcase
			set_capacity(cap);
			lim = (int'(cap) < DEPTH) ? int'(cap) : DEPTH;
			// with a roomy limit, fill to the top so full and long prints show up
			if (lim >= 16) begin
				repeat (lim - gen_count + 2) begin
					queue_op(OP_PUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 32)));
				end
			end
			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 38) op = OP_PUSH;
				else if (r < 52) op = OP_POP;
				else if (r < 60) op = OP_PEEK;
				else if (r < 68) op = OP_DUP;
				else if (r < 78) op = OP_ROTU;
				else if (r < 88) op = OP_ROTD;
				else if (r < 97) op = OP_PRINT;
				else op = OP_UNUSED;
				// aim most rotations within the live entries, the rest anywhere from 0 to 32
				if ($urandom_range(0, 4) != 0)
					depth = 6'($urandom_range(0,
						(gen_count + 1 < DEPTH) ? gen_count + 1 : DEPTH));
				else
					depth = 6'($urandom_range(0, 32));
				queue_op(op, 8'($urandom_range(0, 255)), depth);
			end
		end

		wait_for_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
